// ===== hw/rtl/ssl_pkg.sv =====
// Shared types, constants and the digit table of the seven-segment string loader.
package ssl_pkg;

  localparam int unsigned NumWords = 6;
  localparam int unsigned MaxChars = 5;

  localparam logic [2:0] ColonSlot = 3'd2;
  localparam logic [2:0] SlotAfterColon = 3'd3;
  localparam logic [2:0] SlotLimit = 3'd6;
  localparam logic [2:0] CharLimit = 3'd5;

  localparam logic [7:0] ChrZero  = 8'h30;
  localparam logic [7:0] ChrNine  = 8'h39;
  localparam logic [7:0] ChrDot   = 8'h2E;
  localparam logic [7:0] ChrMinus = 8'h2D;
  localparam logic [7:0] ChrPlus  = 8'h2B;

  localparam logic [15:0] PointBit  = 16'h8000;
  localparam logic [15:0] MinusWord = 16'h4000;
  localparam logic [15:0] BlankWord = 16'h0000;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_CLEAR = 1'b1
  } cmd_e;

  typedef enum logic [2:0] {
    CHAR_DIGIT,
    CHAR_DOT,
    CHAR_MINUS,
    CHAR_PLUS,
    CHAR_OTHER
  } char_kind_e;

  typedef logic [NumWords-1:0][15:0] word_arr_t;

  // Decoded character as the store consumes it.
  typedef struct packed {
    char_kind_e  kind;
    logic [15:0] word;
  } char_info_t;

  // One item as held in the input register.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] char_code;
    logic       justify_left;
    logic       last_char;
  } item_t;

  typedef struct packed {
    logic [2:0] slot_count;
    logic [2:0] chars_seen;
  } store_status_t;

  // gfedcba pattern of a decimal digit.
  function automatic logic [7:0] digit_segments(input logic [3:0] digit);
    logic [7:0] seg;
    case (digit)
      4'd0:    seg = 8'h3F;
      4'd1:    seg = 8'h06;
      4'd2:    seg = 8'h5B;
      4'd3:    seg = 8'h4F;
      4'd4:    seg = 8'h66;
      4'd5:    seg = 8'h6D;
      4'd6:    seg = 8'h7D;
      4'd7:    seg = 8'h07;
      4'd8:    seg = 8'h7F;
      4'd9:    seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

// ===== hw/rtl/ssl_char_decode.sv =====
// Character classifier: turns an ASCII code into a slot word and its kind.
module ssl_char_decode import ssl_pkg::*; (
  input  logic [7:0] char_code_i,
  output char_info_t info_o
);

  always_comb begin
    info_o.kind = CHAR_OTHER;
    info_o.word = BlankWord;
    if (char_code_i >= ChrZero && char_code_i <= ChrNine) begin
      info_o.kind = CHAR_DIGIT;
      info_o.word = {digit_segments(char_code_i[3:0]), 8'h00};
    end else if (char_code_i == ChrDot) begin
      info_o.kind = CHAR_DOT;
    end else if (char_code_i == ChrMinus) begin
      info_o.kind = CHAR_MINUS;
      info_o.word = MinusWord;
    end else if (char_code_i == ChrPlus) begin
      info_o.kind = CHAR_PLUS;
    end
  end

endmodule

// ===== hw/rtl/ssl_word_store.sv =====
// Display word store with slot and character counters, updated once per item.
module ssl_word_store import ssl_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  item_t         item_i,
  input  char_info_t    info_i,
  output word_arr_t     words_o,
  output store_status_t status_o
);

  word_arr_t  words_q, words_d, words_t, words_j;
  logic [2:0] slot_q, slot_d, slot_t;
  logic [2:0] chars_q, chars_d, chars_t;
  logic [2:0] prev_slot;

  assign prev_slot = slot_q - 3'd1;

  // Character step.
  always_comb begin
    words_t = words_q;
    slot_t  = slot_q;
    chars_t = chars_q;
    if (chars_q < CharLimit) begin
      chars_t = chars_q + 3'd1;
      case (info_i.kind)
        CHAR_DIGIT, CHAR_MINUS, CHAR_PLUS: begin
          if (slot_q < SlotLimit) begin
            words_t[slot_q] = info_i.word;
            slot_t = slot_q + 3'd1;
          end
        end
        CHAR_DOT: begin
          // Behind the colon slot the point goes to the digit before it.
          if (slot_q == SlotAfterColon) begin
            words_t[1] = words_q[1] | PointBit;
          end else if (slot_q >= 3'd1 && slot_q <= SlotLimit) begin
            words_t[prev_slot] = words_q[prev_slot] | PointBit;
          end
        end
        default: begin
        end
      endcase
      if (slot_t == ColonSlot) begin
        words_t[ColonSlot] = BlankWord;
        slot_t = SlotAfterColon;
      end
    end
  end

  // Right justification at the end of a string.
  always_comb begin
    words_j = words_t;
    if (!item_i.justify_left) begin
      case (slot_t)
        3'd4: begin
          words_j[4] = words_t[3];
          words_j[3] = words_t[1];
          words_j[1] = words_t[0];
          words_j[2] = BlankWord;
          words_j[0] = BlankWord;
        end
        3'd3: begin
          words_j[4] = words_t[1];
          words_j[3] = words_t[0];
          words_j[2] = BlankWord;
          words_j[1] = BlankWord;
          words_j[0] = BlankWord;
        end
        3'd2: begin
          words_j[4] = words_t[0];
          words_j[3] = BlankWord;
          words_j[2] = BlankWord;
          words_j[1] = BlankWord;
          words_j[0] = BlankWord;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    words_d = words_q;
    slot_d  = slot_q;
    chars_d = chars_q;
    if (fire_i) begin
      if (item_i.cmd == CMD_CLEAR) begin
        words_d = '0;
        slot_d  = '0;
        chars_d = '0;
      end else if (item_i.last_char) begin
        words_d = words_j;
        slot_d  = '0;
        chars_d = '0;
      end else begin
        words_d = words_t;
        slot_d  = slot_t;
        chars_d = chars_t;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      words_q <= '0;
      slot_q  <= '0;
      chars_q <= '0;
    end else begin
      words_q <= words_d;
      slot_q  <= slot_d;
      chars_q <= chars_d;
    end
  end

  assign words_o = words_j;
  assign status_o.slot_count = slot_q;
  assign status_o.chars_seen = chars_q;

endmodule

// ===== hw/rtl/seven_segment_string_loader_top.sv =====
// Top level of the seven-segment string loader: input register, word store, result register.
// An item is registered in the input register on acceptance; its result, if any, is registered when the item fires.
// Throughput: one item per cycle; only a string-ending item that finds the result register
// still held stalls, and the input waits behind it until that result is taken.
// Reset: asynchronous, active low; clears both registers' valid bits, the six display
// words and the slot and character counters.
module seven_segment_string_loader_top import ssl_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic [7:0]  char_code_i,
  input  logic        justify_left_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] word_zero_o,
  output logic [15:0] word_one_o,
  output logic [15:0] word_two_o,
  output logic [15:0] word_three_o,
  output logic [15:0] word_four_o,
  output logic [15:0] word_five_o
);

  logic          s1_vld_q, s1_vld_d;
  item_t         s1_item_q;
  logic          out_vld_q, out_vld_d;
  word_arr_t     out_words_q;
  word_arr_t     words_next;
  char_info_t    info;
  store_status_t status;
  logic          has_result, fire, accept;

  assign has_result = (s1_item_q.cmd == CMD_LOAD) && s1_item_q.last_char;
  assign fire       = s1_vld_q && (!has_result || !out_vld_q || !out_stall_i);
  assign in_stall_o = s1_vld_q && !fire;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    s1_vld_d = s1_vld_q;
    if (accept) begin
      s1_vld_d = 1'b1;
    end else if (fire) begin
      s1_vld_d = 1'b0;
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (fire && has_result) begin
      out_vld_d = 1'b1;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      s1_vld_q  <= s1_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_item_q.cmd          <= cmd_e'(command_i);
      s1_item_q.char_code    <= char_code_i;
      s1_item_q.justify_left <= justify_left_i;
      s1_item_q.last_char    <= last_char_i;
    end
    if (fire && has_result) begin
      out_words_q <= words_next;
    end
  end

  ssl_char_decode u_decode (
    .char_code_i (s1_item_q.char_code),
    .info_o      (info)
  );

  ssl_word_store u_store (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .fire_i   (fire),
    .item_i   (s1_item_q),
    .info_i   (info),
    .words_o  (words_next),
    .status_o (status)
  );

  assign out_valid_o  = out_vld_q;
  assign word_zero_o  = out_words_q[0];
  assign word_one_o   = out_words_q[1];
  assign word_two_o   = out_words_q[2];
  assign word_three_o = out_words_q[3];
  assign word_four_o  = out_words_q[4];
  assign word_five_o  = out_words_q[5];

  a_chars_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.chars_seen <= CharLimit)
    else $error("character count above five");

  a_slot_never_colon: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.slot_count != ColonSlot && status.slot_count <= SlotLimit)
    else $error("slot count rests on the colon slot or beyond the store");

  a_clear_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && s1_item_q.cmd == CMD_CLEAR |=> status.slot_count == 3'd0 &&
    status.chars_seen == 3'd0)
    else $error("clear item left counters set");

  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && has_result |=> out_valid_o)
    else $error("string end gave no result");

endmodule

// ===== sim/seven_segment_string_loader_top_test.sv =====
// Self-checking testbench of the seven-segment string loader: directed table, random strings.
module seven_segment_string_loader_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import ssl_pkg::*;

  // One directed item; want holds the display words from slot five down to slot zero.
  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] code;
    logic       left_just;
    logic       last;
    logic       has_want;
    word_arr_t  want;
  } stim_row_t;

  localparam int NumRows = 25;
  localparam word_arr_t NoWords = '0;

  localparam stim_row_t DirectedRows [NumRows] = '{
    // Clear with the code, justify and last fields high.
    '{CMD_CLEAR, 8'hFF, 1'b1, 1'b1, 1'b0, NoWords},
    '{CMD_LOAD,  8'h38, 1'b1, 1'b1, 1'b1,
      {16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h7F00}},
    '{CMD_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0, NoWords},
    // A lone dot before any digit leaves the cleared store as it is.
    '{CMD_LOAD,  ChrDot, 1'b0, 1'b1, 1'b1, NoWords},
    // "12.34", right justified with all five characters used.
    '{CMD_LOAD,  8'h31, 1'b1, 1'b0, 1'b0, NoWords},
    '{CMD_LOAD,  8'h32, 1'b1, 1'b0, 1'b0, NoWords},
    '{CMD_LOAD,  ChrDot, 1'b0, 1'b0, 1'b0, NoWords},
    '{CMD_LOAD,  8'h33, 1'b1, 1'b0, 1'b0, NoWords},
    '{CMD_LOAD,  8'h34, 1'b0, 1'b1, 1'b0, NoWords},
    // "0.9-" ends on four slots and is moved right.
    '{CMD_LOAD,  ChrZero, 1'b0, 1'b0, 1'b0, NoWords},
    '{CMD_LOAD,  ChrDot, 1'b1, 1'b0, 1'b0, NoWords},
    '{CMD_LOAD,  ChrNine, 1'b0, 1'b0, 1'b0, NoWords},
    '{CMD_LOAD,  ChrMinus, 1'b0, 1'b1, 1'b0, NoWords},
    // Minus, plus, then ignored codes: three slots, moved right.
    '{CMD_LOAD,  ChrMinus, 1'b1, 1'b0, 1'b0, NoWords},
    '{CMD_LOAD,  ChrPlus, 1'b1, 1'b0, 1'b0, NoWords},
    '{CMD_LOAD,  8'h00, 1'b1, 1'b0, 1'b0, NoWords},
    '{CMD_LOAD,  8'hFF, 1'b0, 1'b1, 1'b0, NoWords},
    // A string of one ignored code shows the old store unchanged.
    '{CMD_LOAD,  8'h78, 1'b0, 1'b1, 1'b0, NoWords},
    // Seven digits: only the first five reach the store.
    '{CMD_LOAD,  8'h39, 1'b0, 1'b0, 1'b0, NoWords},
    '{CMD_LOAD,  8'h38, 1'b0, 1'b0, 1'b0, NoWords},
    '{CMD_LOAD,  8'h37, 1'b1, 1'b0, 1'b0, NoWords},
    '{CMD_LOAD,  8'h36, 1'b0, 1'b0, 1'b0, NoWords},
    '{CMD_LOAD,  8'h35, 1'b1, 1'b0, 1'b0, NoWords},
    '{CMD_LOAD,  8'h34, 1'b0, 1'b0, 1'b0, NoWords},
    '{CMD_LOAD,  8'h33, 1'b1, 1'b1, 1'b0, NoWords}
  };

  localparam logic [7:0] SegTable [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        command_i;
  logic [7:0]  char_code_i;
  logic        justify_left_i;
  logic        last_char_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] word_zero_o;
  logic [15:0] word_one_o;
  logic [15:0] word_two_o;
  logic [15:0] word_three_o;
  logic [15:0] word_four_o;
  logic [15:0] word_five_o;

  // Shadow copy of the word store and its counters.
  logic [15:0] shown_words [NumWords];
  int unsigned next_slot;
  int unsigned chars_taken;

  word_arr_t   pending_words[$];
  int unsigned mismatch_count;
  int unsigned items_sent;
  int unsigned tx_idle_pct;
  int unsigned rx_idle_pct;

  seven_segment_string_loader_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .char_code_i   (char_code_i),
    .justify_left_i(justify_left_i),
    .last_char_i   (last_char_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .word_zero_o   (word_zero_o),
    .word_one_o    (word_one_o),
    .word_two_o    (word_two_o),
    .word_three_o  (word_three_o),
    .word_four_o   (word_four_o),
    .word_five_o   (word_five_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  task automatic put_word(input logic [15:0] w);
    if (next_slot < NumWords) begin
      shown_words[next_slot] = w;
      next_slot++;
    end
  endtask

  task automatic track_item(input cmd_e cmd, input logic [7:0] code, input logic left_just,
                            input logic last, output bit done, output word_arr_t words);
    done = 1'b0;
    words = '0;
    if (cmd == CMD_CLEAR) begin
      foreach (shown_words[i]) shown_words[i] = BlankWord;
      next_slot = 0;
      chars_taken = 0;
      return;
    end
    if (chars_taken < MaxChars) begin
      if (code >= ChrZero && code <= ChrNine) begin
        put_word({SegTable[code - ChrZero], 8'h00});
      end else if (code == ChrDot) begin
        // The colon slot has no point, so the digit before it takes the dot.
        if (next_slot == SlotAfterColon) begin
          shown_words[1] |= PointBit;
        end else if (next_slot >= 1) begin
          shown_words[next_slot - 1] |= PointBit;
        end
      end else if (code == ChrMinus) begin
        put_word(MinusWord);
      end else if (code == ChrPlus) begin
        put_word(BlankWord);
      end
      if (next_slot == ColonSlot) put_word(BlankWord);
      chars_taken++;
    end
    if (!last) return;
    if (!left_just) begin
      case (next_slot)
        4: begin
          shown_words[4] = shown_words[3];
          shown_words[3] = shown_words[1];
          shown_words[1] = shown_words[0];
          shown_words[2] = BlankWord;
          shown_words[0] = BlankWord;
        end
        3: begin
          shown_words[4] = shown_words[1];
          shown_words[3] = shown_words[0];
          shown_words[0] = BlankWord;
          shown_words[1] = BlankWord;
          shown_words[2] = BlankWord;
        end
        2: begin
          shown_words[4] = shown_words[0];
          shown_words[3] = BlankWord;
          shown_words[0] = BlankWord;
          shown_words[1] = BlankWord;
          shown_words[2] = BlankWord;
        end
        default: begin
        end
      endcase
    end
    foreach (shown_words[i]) words[i] = shown_words[i];
    done = 1'b1;
    next_slot = 0;
    chars_taken = 0;
  endtask

  task automatic drive_item(input cmd_e cmd, input logic [7:0] code, input logic left_just,
                            input logic last, input logic has_want, input word_arr_t want);
    bit        done;
    word_arr_t words;
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    command_i      <= cmd;
    char_code_i    <= code;
    justify_left_i <= left_just;
    last_char_i    <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    track_item(cmd, code, left_just, last, done, words);
    if (done) pending_words.push_back(has_want ? want : words);
    items_sent++;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_words.size() != 0);
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 50) return ChrZero + 8'($urandom_range(9));
    if (r < 65) return ChrDot;
    if (r < 75) return ChrMinus;
    if (r < 85) return ChrPlus;
    return 8'($urandom_range(255));
  endfunction

  // Mostly whole strings of random characters; some clears, some strings cut short by a clear.
  task automatic send_random_strings(input int unsigned count);
    int unsigned target;
    int unsigned len;
    int unsigned cut;
    target = items_sent + count;
    while (items_sent < target) begin
      if ($urandom_range(99) < 5) begin
        drive_item(CMD_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                   1'($urandom_range(1)), 1'b0, NoWords);
      end else begin
        len = ($urandom_range(9) == 0) ? $urandom_range(8, 6) : $urandom_range(5, 1);
        cut = ($urandom_range(99) < 8) ? $urandom_range(len - 1) : len;
        for (int k = 0; k < len; k++) begin
          if (k == cut) begin
            drive_item(CMD_CLEAR, 8'($urandom_range(255)), 1'($urandom_range(1)),
                       1'($urandom_range(1)), 1'b0, NoWords);
            break;
          end
          drive_item(CMD_LOAD, pick_char(), 1'($urandom_range(1)), k == len - 1,
                     1'b0, NoWords);
        end
      end
    end
  endtask

  always @(posedge clk_i) begin : result_check
    word_arr_t got;
    word_arr_t want;
    got = {word_five_o, word_four_o, word_three_o, word_two_o, word_one_o, word_zero_o};
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $time, got);
        mismatch_count++;
      end else begin
        want = pending_words.pop_front();
        for (int i = 0; i < NumWords; i++) begin
          if (got[i] !== want[i]) begin
            $display("%0t: word %0d expected %h actual %h", $time, i, want[i], got[i]);
            mismatch_count++;
          end
        end
      end
    end
    out_stall_i <= ($urandom_range(99) < rx_idle_pct);
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    command_i      = CMD_LOAD;
    char_code_i    = 8'h00;
    justify_left_i = 1'b0;
    last_char_i    = 1'b0;
    foreach (shown_words[i]) shown_words[i] = BlankWord;
    next_slot      = 0;
    chars_taken    = 0;
    mismatch_count = 0;
    items_sent     = 0;
    tx_idle_pct    = 21;
    rx_idle_pct    = 48;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int r = 0; r < NumRows; r++) begin
      drive_item(DirectedRows[r].cmd, DirectedRows[r].code, DirectedRows[r].left_just,
                 DirectedRows[r].last, DirectedRows[r].has_want, DirectedRows[r].want);
    end
    send_random_strings(140);
    wait_for_results();

    tx_idle_pct = 48;
    rx_idle_pct = 21;
    send_random_strings(145);
    wait_for_results();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_strings(145);
    wait_for_results();
    repeat (4) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
